// ===== sv/lse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Shared constants, phase encoding and configuration types.
// ----------------------------------------------------------------------------
package lse_pkg;

   localparam int LSE_LENGTH_BITS = 24;
   localparam int HEADER_SKIP_WIDTH = 10;
   localparam logic [HEADER_SKIP_WIDTH-1:0] HEADER_SKIP_RESET = 10'd54;
   localparam logic [7:0] LENGTH_CONTINUE = 8'd255;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_HEADER_SKIP = 1'b0;

   localparam logic [3:0] DEPTH_1 = 4'd1;
   localparam logic [3:0] DEPTH_2 = 4'd2;
   localparam logic [3:0] DEPTH_4 = 4'd4;
   localparam logic [3:0] DEPTH_8 = 4'd8;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_LENGTH = 5'b00010,
      PH_DEPTH  = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [HEADER_SKIP_WIDTH-1:0] header_skip;
   } cfg_type;

endpackage

// ===== sv/lse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego extractor channels
// Valid/ready channels for image bytes in and message bytes out.
// ----------------------------------------------------------------------------
interface lse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] image_byte;
   logic       image_start;

   modport source (output valid, output image_byte, output image_start, input ready);
   modport sink (input valid, input image_byte, input image_start, output ready);
endinterface

interface lse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       message_last;
   logic       depth_error;

   modport source (output valid, output message_byte, output message_last,
                   output depth_error, input ready);
   modport sink (input valid, input message_byte, input message_last,
                 input depth_error, output ready);
endinterface

// ===== sv/lsb_stego_extract_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego extractor
// Recovers a message hidden in the low bits of a stream of image bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Carries
//   req_chan  in         valid/ready            image_byte, image_start
//   rsp_chan  out        valid/ready            message_byte, message_last, depth_error
//   csr_*     in         APB-style, pready = 1  header_skip at byte address 0
//
// One image byte is accepted in every cycle; a result appears in the cycle after
// the byte that completes it, from the result register in the core.
// The result register decouples the two sides: a new byte is taken as a
// finished result leaves, so the rate drops only while a held result is stalled.
// Reset is synchronous and active high; it restores header_skip to 54 and
// returns the parser to header skipping with all counters cleared.
// A byte with image_start set restarts extraction and is itself the first byte.
//
module lsb_stego_extract_top #(
   parameter int LENGTH_BITS = lse_pkg::LSE_LENGTH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   lse_req_if.sink                             req_chan,
   lse_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lse_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [lse_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [lse_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   // Configuration seen by the parser. The user must change it only while no
   // transfer is in flight; the block does not enforce this itself.
   lse_pkg::cfg_type cfg;

   lse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The core walks header, length, depth and data phases, one byte per
   // transfer, and holds each recovered byte in its result register until
   // the downstream transfer completes.
   lse_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sv/lse_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego extractor register file
// APB-style port holding the header skip count.
// ----------------------------------------------------------------------------
module lse_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lse_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [lse_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [lse_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output lse_pkg::cfg_type                    cfg
);

   logic [lse_pkg::HEADER_SKIP_WIDTH-1:0] header_skip_ff;
   logic [lse_pkg::HEADER_SKIP_WIDTH-1:0] header_skip_in;
   logic                                  write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == lse_pkg::REG_HEADER_SKIP);

   always_comb begin
      header_skip_in = header_skip_ff;
      if (write_hit) begin
         header_skip_in = csr_pwdata[lse_pkg::HEADER_SKIP_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= lse_pkg::HEADER_SKIP_RESET;
      end else begin
         header_skip_ff <= header_skip_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lse_pkg::REG_HEADER_SKIP) begin
         csr_prdata = {{(lse_pkg::CSR_DATA_WIDTH-lse_pkg::HEADER_SKIP_WIDTH){1'b0}},
                       header_skip_ff};
      end
   end

   assign cfg.header_skip = header_skip_ff;

endmodule

// ===== sv/lse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego extractor core
// Parse state, bit gathering and the result register.
// ----------------------------------------------------------------------------
module lse_core #(
   parameter int LENGTH_BITS = lse_pkg::LSE_LENGTH_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  lse_pkg::cfg_type cfg,
   lse_req_if.sink          req_chan,
   lse_rsp_if.source        rsp_chan
);

   lse_pkg::phase_type                    phase_ff, phase_in, cur_phase;
   logic [lse_pkg::HEADER_SKIP_WIDTH-1:0] header_count_ff, header_count_in, cur_hc;
   logic [LENGTH_BITS-1:0]                length_ff, length_in, cur_len;
   logic [LENGTH_BITS-1:0]                emitted_ff, emitted_in, emitted_next;
   logic [3:0]                            depth_ff, depth_in;
   logic [7:0]                            acc_ff, acc_in, acc_next;
   logic [3:0]                            chunk_ff, chunk_in, chunk_next, chunk_need;
   logic [LENGTH_BITS:0]                  length_sum;
   logic                                  accept;
   logic                                  emit;
   logic [7:0]                            emit_byte;
   logic                                  emit_last;
   logic                                  emit_error;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]                            rsp_byte_ff;
   logic                                  rsp_last_ff;
   logic                                  rsp_error_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // A start byte sees the cleared state.
   assign cur_phase   = req_chan.image_start ? lse_pkg::PH_HEADER : phase_ff;
   assign cur_hc      = req_chan.image_start ? '0 : header_count_ff;
   assign cur_len     = req_chan.image_start ? '0 : length_ff;

   assign length_sum   = {1'b0, cur_len}
                       + {{(LENGTH_BITS-7){1'b0}}, req_chan.image_byte};
   assign emitted_next = emitted_ff + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
   assign chunk_next   = chunk_ff + 4'd1;

   always_comb begin
      case (depth_ff)
         lse_pkg::DEPTH_1: begin
            acc_next   = {acc_ff[6:0], req_chan.image_byte[0]};
            chunk_need = 4'd8;
         end
         lse_pkg::DEPTH_2: begin
            acc_next   = {acc_ff[5:0], req_chan.image_byte[1:0]};
            chunk_need = 4'd4;
         end
         lse_pkg::DEPTH_4: begin
            acc_next   = {acc_ff[3:0], req_chan.image_byte[3:0]};
            chunk_need = 4'd2;
         end
         default: begin
            acc_next   = req_chan.image_byte;
            chunk_need = 4'd1;
         end
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      length_in       = length_ff;
      emitted_in      = emitted_ff;
      depth_in        = depth_ff;
      acc_in          = acc_ff;
      chunk_in        = chunk_ff;
      emit            = 1'b0;
      emit_byte       = 8'd0;
      emit_last       = 1'b0;
      emit_error      = 1'b0;
      if (accept) begin
         if (req_chan.image_start) begin
            phase_in        = lse_pkg::PH_HEADER;
            header_count_in = '0;
            length_in       = '0;
            emitted_in      = '0;
            depth_in        = '0;
            acc_in          = '0;
            chunk_in        = '0;
         end
         case (cur_phase)
            lse_pkg::PH_HEADER, lse_pkg::PH_LENGTH: begin
               if ((cur_phase == lse_pkg::PH_HEADER) && (cur_hc < cfg.header_skip)) begin
                  header_count_in = cur_hc + 1'b1;
               end else begin
                  // The first byte past the header is already a length byte.
                  length_in = length_sum[LENGTH_BITS] ? '1 : length_sum[LENGTH_BITS-1:0];
                  phase_in  = (req_chan.image_byte == lse_pkg::LENGTH_CONTINUE)
                              ? lse_pkg::PH_LENGTH : lse_pkg::PH_DEPTH;
               end
            end
            lse_pkg::PH_DEPTH: begin
               if (req_chan.image_byte inside {8'd1, 8'd2, 8'd4, 8'd8}) begin
                  depth_in = req_chan.image_byte[3:0];
                  acc_in   = '0;
                  chunk_in = '0;
                  phase_in = (cur_len == '0) ? lse_pkg::PH_DONE : lse_pkg::PH_DATA;
               end else begin
                  phase_in   = lse_pkg::PH_DONE;
                  emit       = 1'b1;
                  emit_last  = 1'b1;
                  emit_error = 1'b1;
               end
            end
            lse_pkg::PH_DATA: begin
               if (chunk_next < chunk_need) begin
                  acc_in   = acc_next;
                  chunk_in = chunk_next;
               end else begin
                  emitted_in = emitted_next;
                  emit       = 1'b1;
                  emit_byte  = acc_next;
                  emit_last  = (emitted_next >= length_ff);
                  acc_in     = '0;
                  chunk_in   = '0;
                  if (emitted_next >= length_ff) begin
                     phase_in = lse_pkg::PH_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lse_pkg::PH_HEADER;
         header_count_ff <= '0;
         length_ff       <= '0;
         emitted_ff      <= '0;
         depth_ff        <= '0;
         acc_ff          <= '0;
         chunk_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         length_ff       <= length_in;
         emitted_ff      <= emitted_in;
         depth_ff        <= depth_in;
         acc_ff          <= acc_in;
         chunk_ff        <= chunk_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_byte_ff  <= emit_byte;
         rsp_last_ff  <= emit_last;
         rsp_error_ff <= emit_error;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.message_byte = rsp_byte_ff;
   assign rsp_chan.message_last = rsp_last_ff;
   assign rsp_chan.depth_error  = rsp_error_ff;

endmodule

// ===== sv/lse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego extractor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_message_byte,
   input logic       rsp_message_last,
   input logic       rsp_depth_error
);

   // An error result carries a zero byte and closes the message.
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_depth_error) |-> (rsp_message_last && (rsp_message_byte == 8'd0)))
      else $error("depth error result malformed");

   // With no result held, the block always takes the next byte.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // A new result only follows an accepted input byte.
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid && req_ready))
      else $error("result without an accepted byte");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_message_byte)
                                     && $stable(rsp_message_last) && $stable(rsp_depth_error)))
      else $error("stalled result changed");

endmodule

bind lsb_stego_extract_top lse_checker u_lse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_message_byte (rsp_chan.message_byte),
   .rsp_message_last (rsp_chan.message_last),
   .rsp_depth_error  (rsp_chan.depth_error)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego extractor testbench
// Streams stego images with directed and random content into the extractor,
// predicts every recovered message byte and depth error in a scoreboard, and
// compares each result transfer field by field under changing traffic mixes.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LEN_BITS    = lse_pkg::LSE_LENGTH_BITS;
   localparam int SKIP_W      = lse_pkg::HEADER_SKIP_WIDTH;
   localparam int ADDR_W      = lse_pkg::CSR_ADDR_WIDTH;
   localparam int DATA_W      = lse_pkg::CSR_DATA_WIDTH;
   localparam int CYCLE_LIMIT = 50_000;
   // The only register sits at byte address zero.
   localparam logic [ADDR_W-1:0] HEADER_SKIP_ADDR =
      ADDR_W'(4 * int'(lse_pkg::REG_HEADER_SKIP));

   typedef struct packed {
      logic [7:0] image_byte;
      logic       image_start;
   } image_item_type;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       message_last;
      logic       depth_error;
   } message_type;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the extractor state, turns every
   // accepted image byte into zero or one expected message transfer, and
   // compares each result transfer against the oldest expectation.
   // -------------------------------------------------------------------------
   class extract_scoreboard;
      logic [SKIP_W-1:0]   header_skip;
      lse_pkg::phase_type  phase;
      logic [SKIP_W-1:0]   header_count;
      logic [LEN_BITS-1:0] message_length;
      logic [LEN_BITS-1:0] bytes_emitted;
      logic [3:0]          pack_depth;
      logic [7:0]          accumulator;
      logic [3:0]          chunk_count;
      message_type         message_q[$];
      int                  mismatches;
      int                  bytes_seen;
      int                  results_seen;
      int                  errors_seen;

      function new();
         header_skip  = lse_pkg::HEADER_SKIP_RESET;
         mismatches   = 0;
         bytes_seen   = 0;
         results_seen = 0;
         errors_seen  = 0;
         clear_image();
      endfunction

      static function bit depth_supported(input logic [7:0] b);
         return b == {4'b0, lse_pkg::DEPTH_1} || b == {4'b0, lse_pkg::DEPTH_2} ||
                b == {4'b0, lse_pkg::DEPTH_4} || b == {4'b0, lse_pkg::DEPTH_8};
      endfunction

      function void clear_image();
         phase          = lse_pkg::PH_HEADER;
         header_count   = '0;
         message_length = '0;
         bytes_emitted  = '0;
         pack_depth     = '0;
         accumulator    = '0;
         chunk_count    = '0;
      endfunction

      function void set_header_skip(input logic [SKIP_W-1:0] v);
         header_skip = v;
      endfunction

      function int pending();
         return message_q.size();
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH at %0t ns: %s", $time, what);
         mismatches++;
      endtask

      function void note_image_byte(input logic [7:0] b, input logic start);
         logic [LEN_BITS:0] sum;
         logic [7:0]        mask;
         message_type       m;
         bytes_seen++;
         if (start)
            clear_image();
         if (phase == lse_pkg::PH_HEADER) begin
            if (header_count < header_skip) begin
               header_count++;
               return;
            end
            phase = lse_pkg::PH_LENGTH;
         end
         case (phase)
            lse_pkg::PH_LENGTH: begin
               // Length bytes add up, saturating at the top of the counter.
               sum = {1'b0, message_length} + (LEN_BITS + 1)'(b);
               message_length = sum[LEN_BITS] ? '1 : sum[LEN_BITS-1:0];
               if (b != lse_pkg::LENGTH_CONTINUE)
                  phase = lse_pkg::PH_DEPTH;
            end
            lse_pkg::PH_DEPTH: begin
               if (depth_supported(b)) begin
                  pack_depth  = b[3:0];
                  accumulator = '0;
                  chunk_count = '0;
                  phase = (message_length == '0) ? lse_pkg::PH_DONE : lse_pkg::PH_DATA;
               end else begin
                  phase = lse_pkg::PH_DONE;
                  m = '{message_byte: 8'h00, message_last: 1'b1, depth_error: 1'b1};
                  message_q.push_back(m);
               end
            end
            lse_pkg::PH_DATA: begin
               mask = 8'((1 << pack_depth) - 1);
               accumulator = (accumulator << pack_depth) | (b & mask);
               chunk_count++;
               if (chunk_count == 4'(8 / int'(pack_depth))) begin
                  bytes_emitted++;
                  m.message_byte = accumulator;
                  m.message_last = (bytes_emitted >= message_length);
                  m.depth_error  = 1'b0;
                  message_q.push_back(m);
                  accumulator = '0;
                  chunk_count = '0;
                  if (m.message_last)
                     phase = lse_pkg::PH_DONE;
               end
            end
            default: ;
         endcase
      endfunction

      task check_result(input message_type got);
         message_type want;
         results_seen++;
         if (got.depth_error)
            errors_seen++;
         if (message_q.size() == 0) begin
            report_mismatch($sformatf("result %0h/%0b/%0b with nothing expected",
                                      got.message_byte, got.message_last,
                                      got.depth_error));
            return;
         end
         want = message_q.pop_front();
         if (got.message_byte !== want.message_byte)
            report_mismatch($sformatf("message_byte %02h, expected %02h",
                                      got.message_byte, want.message_byte));
         if (got.message_last !== want.message_last)
            report_mismatch($sformatf("message_last %b, expected %b",
                                      got.message_last, want.message_last));
         if (got.depth_error !== want.depth_error)
            report_mismatch($sformatf("depth_error %b, expected %b",
                                      got.depth_error, want.depth_error));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block itself.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always #4 clock = ~clock;

   lse_req_if req_if();
   lse_rsp_if rsp_if();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   lsb_stego_extract_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if.sink),
      .rsp_chan    (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   extract_scoreboard sb = new();

   // Traffic controls shared between the stimulus and the receiver.
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  hold_len_req   = 0;
   bit  hold_taken     = 1'b0;
   int  cycle_count    = 0;

   image_item_type    stim_q[$];
   bit                start_next;
   logic [SKIP_W-1:0] skip_now;

   // -------------------------------------------------------------------------
   // Monitor. Both channels are sampled at the rising edge, where the values
   // seen are the ones that held during the cycle that just ended. Results
   // are checked before the input of the same edge is noted; a result can
   // never stem from a byte taken at that very edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result('{message_byte: rsp_if.message_byte,
                              message_last: rsp_if.message_last,
                              depth_error:  rsp_if.depth_error});
         if (req_if.valid && req_if.ready)
            sb.note_image_byte(req_if.image_byte, req_if.image_start);
      end
   end

   // Runaway guard: ends the run once cycle_count reaches CYCLE_LIMIT, progress or not.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. Stalls at random according to recv_stall_pct. When a long
   // hold-off is requested it takes the request once and counts the stretch
   // down itself, so the sender keeps pushing bytes into a blocked block.
   // -------------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len_req != 0 && !hold_taken) begin
            hold_left  = hold_len_req;
            hold_taken = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Image building. Bytes are queued first and sent later by play_stimulus.
   // The first queued byte of an image carries the start flag when asked.
   // -------------------------------------------------------------------------
   function automatic void push_byte(input logic [7:0] b);
      stim_q.push_back('{image_byte: b, image_start: start_next});
      start_next = 1'b0;
   endfunction

   // Lengths of 255 or more are written as a run of 255s closed by the rest.
   function automatic void push_length(input int len);
      while (len >= 255) begin
         push_byte(lse_pkg::LENGTH_CONTINUE);
         len -= 255;
      end
      push_byte(8'(len));
   endfunction

   // Returns how many of the queued bytes the block actually works on; the
   // trailing bytes after the message are ignored by design.
   function automatic int build_image(input bit with_start, input int hdr_n,
                                      input int len, input logic [7:0] depth_byte,
                                      input int data_n, input int tail_n);
      int used;
      used = stim_q.size();
      start_next = with_start;
      repeat (hdr_n) push_byte(8'($urandom_range(255)));
      push_length(len);
      push_byte(depth_byte);
      repeat (data_n) push_byte(8'($urandom_range(255)));
      used = stim_q.size() - used;
      repeat (tail_n) push_byte(8'($urandom_range(255)));
      return used;
   endfunction

   // -------------------------------------------------------------------------
   // Driver tasks.
   // -------------------------------------------------------------------------
   // Sends every queued byte. Valid stays high from one byte to the next
   // unless an idle gap is drawn, so back-to-back transfers happen too.
   task automatic play_stimulus();
      image_item_type it;
      while (stim_q.size() != 0) begin
         it = stim_q.pop_front();
         if (send_idle_pct != 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
            end
         end
         req_if.valid       <= 1'b1;
         req_if.image_byte  <= it.image_byte;
         req_if.image_start <= it.image_start;
         @(posedge clock);
         while (!req_if.ready)
            @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected result has been taken.
   // A byte that makes no result may still be in flight after that, so the
   // task waits on for it to settle before anything touches the register.
   task automatic wait_drain();
      req_if.valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_transfer(input logic wr, input logic [DATA_W-1:0] wdata,
                               output logic [DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= HEADER_SKIP_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_header_skip();
      logic [DATA_W-1:0] rd;
      csr_transfer(1'b0, '0, rd);
      if (rd[SKIP_W-1:0] !== sb.header_skip)
         sb.report_mismatch($sformatf("header_skip reads %0d, expected %0d",
                                      rd[SKIP_W-1:0], sb.header_skip));
   endtask

   // Only called with the block idle: right after a drain.
   task automatic set_header_skip(input logic [SKIP_W-1:0] v);
      logic [DATA_W-1:0] rd;
      csr_transfer(1'b1, DATA_W'(v), rd);
      sb.set_header_skip(v);
      skip_now = v;
      check_header_skip();
   endtask

   // -------------------------------------------------------------------------
   // Random images. Most are well formed with random content so that the
   // data phase is reached often; the rest are truncated images, bad depth
   // bytes, empty messages, long length fields and plain noise.
   // -------------------------------------------------------------------------
   task automatic random_images(input int target);
      int         done_n;
      int         kind;
      int         len;
      int         data_n;
      logic [7:0] depth_byte;
      done_n = 0;
      while (done_n < target) begin
         kind       = $urandom_range(99);
         len        = $urandom_range(3, 1);
         depth_byte = 8'(1 << $urandom_range(3));
         data_n     = len * 8 / int'(depth_byte);
         if (kind < 70) begin
            done_n += build_image(1'b1, skip_now, len, depth_byte, data_n,
                                  ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0);
         end else if (kind < 78) begin
            // Cut short; the next image restarts in the middle of this one.
            done_n += build_image(1'b1, skip_now, len, depth_byte,
                                  $urandom_range(data_n - 1), 0);
         end else if (kind < 84) begin
            do
               depth_byte = 8'($urandom_range(255));
            while (extract_scoreboard::depth_supported(depth_byte));
            done_n += build_image(1'b1, skip_now, len, depth_byte, 0,
                                  $urandom_range(3));
         end else if (kind < 88) begin
            done_n += build_image(1'b1, skip_now, 0, depth_byte, 0,
                                  $urandom_range(3));
         end else if (kind < 90) begin
            // Length field with a continuation byte, packed one byte per byte
            // and cut short after a few data bytes.
            len = 255 + $urandom_range(4);
            done_n += build_image(1'b1, skip_now, len, {4'b0, lse_pkg::DEPTH_8},
                                  $urandom_range(4), 0);
         end else begin
            repeat ($urandom_range(8, 1)) begin
               start_next = ($urandom_range(3) == 0);
               push_byte(8'($urandom_range(255)));
               done_n++;
            end
         end
         play_stimulus();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int                n;
      int                idle_mix[4];
      int                stall_mix[4];
      logic [SKIP_W-1:0] skip_mix[4];
      idle_mix  = '{0, 51, 0, 34};
      stall_mix = '{0, 0, 51, 34};
      skip_mix  = '{0, 5, 1, 12};

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.image_byte  <= '0;
      req_if.image_start <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      skip_now            = lse_pkg::HEADER_SKIP_RESET;
      start_next          = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- Directed part ----
      // The register must come out of reset at its default skip of 54.
      check_header_skip();

      // An image that arrives without any start flag is taken from reset:
      // default header, two message bytes at depth 8 with all-zero and
      // all-one content, then a byte past the end that must be ignored.
      n = build_image(1'b0, skip_now, 2, {4'b0, lse_pkg::DEPTH_8}, 0, 0);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h5A);
      play_stimulus();
      wait_drain();

      // No header at all: the start byte itself is the length field.
      set_header_skip('0);
      n = build_image(1'b1, 0, 1, {4'b0, lse_pkg::DEPTH_1}, 8, 0);
      n = build_image(1'b1, 0, 1, {4'b0, lse_pkg::DEPTH_2}, 4, 0);
      n = build_image(1'b1, 0, 2, {4'b0, lse_pkg::DEPTH_4}, 4, 0);
      // Unsupported depths, including one whose low nibble looks legal.
      n = build_image(1'b1, 0, 1, 8'h00, 0, 2);
      n = build_image(1'b1, 0, 1, 8'h03, 0, 0);
      n = build_image(1'b1, 0, 1, 8'h10, 0, 1);
      n = build_image(1'b1, 0, 1, 8'h81, 0, 0);
      n = build_image(1'b1, 0, 1, 8'hFF, 0, 1);
      // An empty message gives nothing; a bad depth still reports an error.
      n = build_image(1'b1, 0, 0, {4'b0, lse_pkg::DEPTH_8}, 0, 3);
      n = build_image(1'b1, 0, 0, 8'h05, 0, 1);
      // Restart in the middle of a message.
      n = build_image(1'b1, 0, 3, {4'b0, lse_pkg::DEPTH_2}, 5, 0);
      // A length of exactly 255 is written as 255 followed by 0; the image
      // stops after a few message bytes, none of them the last one.
      n = build_image(1'b1, 0, 255, {4'b0, lse_pkg::DEPTH_8}, 3, 0);
      play_stimulus();
      wait_drain();

      // Lower the skip while a header is being passed over: the block has
      // already counted past the new value, so the next byte is the length.
      set_header_skip(10'd10);
      start_next = 1'b1;
      repeat (6) push_byte(8'($urandom_range(255)));
      play_stimulus();
      wait_drain();
      set_header_skip(10'd3);
      n = build_image(1'b0, 0, 1, {4'b0, lse_pkg::DEPTH_8}, 1, 0);
      play_stimulus();
      wait_drain();

      // The widest skip value the register holds reads back whole.
      set_header_skip('1);

      // ---- Random part, one traffic mix per pass ----
      for (int p = 0; p < 4; p++) begin
         set_header_skip(skip_mix[p]);
         send_idle_pct  = idle_mix[p];
         recv_stall_pct = stall_mix[p];
         if (p == 0) begin
            random_images(40);
            // Long receiver hold-off while depth-8 images keep coming, so the
            // result register fills and the input gets back-pressured.
            hold_len_req = 200;
            repeat (4)
               n = build_image(1'b1, skip_now, 6, {4'b0, lse_pkg::DEPTH_8}, 6, 0);
            play_stimulus();
            // Sender pause until every outstanding result has come out.
            wait_drain();
            random_images(40);
         end else begin
            random_images(90);
         end
         wait_drain();
      end

      wait_drain();
      repeat (8) @(posedge clock);

      $display("Run covered %0d image bytes and %0d result transfers (%0d depth errors)",
               sb.bytes_seen, sb.results_seen, sb.errors_seen);
      $display("Header skips 0 to 54 streamed, 1023 read back; all depths, bad depths, "
               , "empty and multi-byte lengths");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
